// ===== hdl/scnv_pkg.sv =====
// shared constants, types and edge table for the surface nets cell vertex block
// no dependencies
package scnv_pkg;

  // field widths
  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = 8;
  localparam int FRAC_BITS   = 8;
  localparam int GUARD       = 4;
  localparam int TFRAC       = FRAC_BITS + GUARD;
  localparam int CENTER_BITS = 17;
  localparam int NORMAL_BITS = 16;
  localparam int ONE_BITS    = 14;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_AXES    = 3;
  localparam int NUM_EDGES   = 12;

  // edge crossing divider
  localparam int MAG_BITS   = SAMPLE_BITS + 1;
  localparam int DEN_BITS   = MAG_BITS;
  localparam int NUM_BITS   = MAG_BITS + TFRAC;
  localparam int T_BITS     = TFRAC + 1;
  localparam int EDGE_STEPS = T_BITS;

  // crossing sums and averaging divider
  localparam int NUM_GROUPS    = 3;
  localparam int GROUP_EDGES   = NUM_EDGES / NUM_GROUPS;
  localparam int GSUM_BITS     = TFRAC + 3;
  localparam int GCNT_BITS     = 3;
  localparam int CNT_BITS      = 4;
  localparam int AVG_NUM_BITS  = TFRAC + 4;
  localparam int AVG_DEN_BITS  = CNT_BITS + GUARD;
  localparam int AVG_STEPS     = FRAC_BITS + 1;
  localparam int CELL_DELAY    = 1 + EDGE_STEPS + 2 + AVG_STEPS;
  localparam int CENTER_LAT    = CELL_DELAY + 1;

  // gradient, normalizing divider and square root
  localparam int GRAD_BITS  = SAMPLE_BITS + 3;
  localparam int AG_BITS    = GRAD_BITS - 1;
  localparam int SQ_BITS    = 2 * AG_BITS;
  localparam int LEN_BITS   = SQ_BITS + 2;
  localparam int Q_BITS     = 2 * ONE_BITS + 3;
  localparam int QDIV_STEPS = Q_BITS;
  localparam int ROOT_STEPS = 16;
  localparam int ROOT_BITS  = 2 * ROOT_STEPS;
  localparam int FLAG_DELAY = QDIV_STEPS + ROOT_STEPS;
  localparam int NORMAL_LAT = 3 + QDIV_STEPS + ROOT_STEPS + 1;

  // top level alignment
  localparam int ALIGN_DELAY = NORMAL_LAT - CENTER_LAT;
  localparam int PIPE_LAST   = NORMAL_LAT + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic [CENTER_BITS-1:0]        center_t;
  typedef logic signed [NORMAL_BITS-1:0] normal_t;

  typedef struct packed {
    logic    has;
    center_t x;
    center_t y;
    center_t z;
  } center_res_t;

  typedef struct packed {
    normal_t x;
    normal_t y;
    normal_t z;
    logic    zero;
  } normal_res_t;

  // first corner of each cube edge
  function automatic logic [2:0] edge_a(input int e);
    logic [2:0] c;
    case (e)
      0, 1, 2: c = 3'd0;
      3, 4:    c = 3'd4;
      5, 6:    c = 3'd2;
      7:       c = 3'd6;
      8, 9:    c = 3'd1;
      10:      c = 3'd5;
      11:      c = 3'd3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // second corner of each cube edge
  function automatic logic [2:0] edge_b(input int e);
    logic [2:0] c;
    case (e)
      0:       c = 3'd4;
      1:       c = 3'd2;
      2:       c = 3'd1;
      3:       c = 3'd6;
      4:       c = 3'd5;
      5:       c = 3'd6;
      6:       c = 3'd3;
      7:       c = 3'd7;
      8:       c = 3'd5;
      9:       c = 3'd3;
      10:      c = 3'd7;
      11:      c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // magnitude of a sample, one bit wider
  function automatic logic [MAG_BITS-1:0] mag_of(input sample_t v);
    logic [MAG_BITS-1:0] ext;
    ext = {v[SAMPLE_BITS-1], v};
    return v[SAMPLE_BITS-1] ? (~ext + MAG_BITS'(1)) : ext;
  endfunction

endpackage

// ===== hdl/surface_nets_cell_vertex.sv =====
// surface nets cell vertex: one voxel cell in, one vertex and normal out
// depth: input register plus 52 register stages before out_valid
// throughput: one request per cycle; the whole pipeline holds while a result waits
// the normal path (31-stage divider plus 16-stage square root) sets the depth
// reset clears only the valid bits; data registers need no reset
// depends on scnv_pkg, scnv_center, scnv_normal
module surface_nets_cell_vertex import scnv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t corner_0,
  input  sample_t corner_1,
  input  sample_t corner_2,
  input  sample_t corner_3,
  input  sample_t corner_4,
  input  sample_t corner_5,
  input  sample_t corner_6,
  input  sample_t corner_7,
  input  coord_t  cell_x,
  input  coord_t  cell_y,
  input  coord_t  cell_z,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    has_vertex,
  output center_t center_x,
  output center_t center_y,
  output center_t center_z,
  output normal_t norm_x,
  output normal_t norm_y,
  output normal_t norm_z,
  output logic    normal_zero
);

  logic                      en;
  logic [PIPE_LAST:0]        vld;
  sample_t [NUM_CORNERS-1:0] corner_s;
  coord_t  [NUM_AXES-1:0]    cell_s;
  center_res_t               center_res;
  normal_res_t               normal_res;
  center_res_t               center_d [ALIGN_DELAY];

  // the whole pipeline advances unless a finished result is held
  assign en        = !vld[PIPE_LAST] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PIPE_LAST];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAST-1:0], in_valid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      corner_s <= {corner_7, corner_6, corner_5, corner_4,
                   corner_3, corner_2, corner_1, corner_0};
      cell_s   <= {cell_z, cell_y, cell_x};
    end
  end

  scnv_center u_center (
    .clk     (clk),
    .en      (en),
    .corners (corner_s),
    .coords  (cell_s),
    .res     (center_res)
  );

  scnv_normal u_normal (
    .clk     (clk),
    .en      (en),
    .corners (corner_s),
    .res     (normal_res)
  );

  // hold the vertex until the normal catches up
  always_ff @(posedge clk) begin
    if (en) begin
      center_d[0] <= center_res;
      for (int i = 1; i < ALIGN_DELAY; i++) center_d[i] <= center_d[i-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      has_vertex  <= center_d[ALIGN_DELAY-1].has;
      center_x    <= center_d[ALIGN_DELAY-1].x;
      center_y    <= center_d[ALIGN_DELAY-1].y;
      center_z    <= center_d[ALIGN_DELAY-1].z;
      norm_x      <= center_d[ALIGN_DELAY-1].has ? normal_res.x : '0;
      norm_y      <= center_d[ALIGN_DELAY-1].has ? normal_res.y : '0;
      norm_z      <= center_d[ALIGN_DELAY-1].has ? normal_res.z : '0;
      normal_zero <= center_d[ALIGN_DELAY-1].has & normal_res.zero;
    end
  end

endmodule

// ===== hdl/scnv_edge_div.sv =====
// pipelined restoring divider for one edge crossing fraction, one quotient bit per stage
// depends on scnv_pkg
module scnv_edge_div import scnv_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [T_BITS-1:0]   quot
);

  logic [NUM_BITS-1:0] rem_q [EDGE_STEPS];
  logic [DEN_BITS-1:0] den_q [EDGE_STEPS];
  logic [T_BITS-1:0]   quo_q [EDGE_STEPS];

  for (genvar i = 0; i < EDGE_STEPS; i++) begin : g_step
    logic [NUM_BITS-1:0] rem_in;
    logic [DEN_BITS-1:0] den_in;
    logic [T_BITS-1:0]   quo_in;
    logic [NUM_BITS:0]   trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // compare against the shifted divisor
    assign trial = {{(NUM_BITS + 1 - DEN_BITS){1'b0}}, den_in} << (EDGE_STEPS - 1 - i);
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? (rem_in - trial[NUM_BITS-1:0]) : rem_in;
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[T_BITS-2:0], ge};
      end
    end
  end

  assign quot = quo_q[EDGE_STEPS-1];

endmodule

// ===== hdl/scnv_center.sv =====
// vertex position path: edge crossings, per-axis sums, averaging divider, cell offset
// depends on scnv_pkg and scnv_edge_div
module scnv_center import scnv_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  sample_t [NUM_CORNERS-1:0]     corners,
  input  coord_t  [NUM_AXES-1:0]        coords,
  output center_res_t                   res
);

  localparam logic [GSUM_BITS-1:0] ONE_T = GSUM_BITS'(1) << TFRAC;

  logic [NUM_BITS-1:0]  num_r   [NUM_EDGES];
  logic [DEN_BITS-1:0]  den_r   [NUM_EDGES];
  logic                 cross_r [NUM_EDGES];
  logic [T_BITS-1:0]    t_q     [NUM_EDGES];
  logic [NUM_EDGES-1:0] cross_vec;
  logic [NUM_EDGES-1:0] cross_d [EDGE_STEPS];
  coord_t [NUM_AXES-1:0] cell_d [CELL_DELAY];

  // edge setup and crossing dividers
  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    localparam logic [2:0] A = edge_a(e);
    localparam logic [2:0] B = edge_b(e);
    logic [MAG_BITS-1:0] mag_a;
    logic [MAG_BITS-1:0] mag_b;
    logic [DEN_BITS-1:0] den_c;

    assign mag_a = mag_of(corners[A]);
    assign mag_b = mag_of(corners[B]);
    assign den_c = mag_a + mag_b;

    always_ff @(posedge clk) begin
      if (en) begin
        cross_r[e] <= corners[A][SAMPLE_BITS-1] ^ corners[B][SAMPLE_BITS-1];
        den_r[e]   <= den_c;
        num_r[e]   <= {mag_a, {TFRAC{1'b0}}} + NUM_BITS'(den_c >> 1);
      end
    end

    assign cross_vec[e] = cross_r[e];

    scnv_edge_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (num_r[e]),
      .den  (den_r[e]),
      .quot (t_q[e])
    );
  end

  // crossing flags and cell coordinates follow the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      cross_d[0] <= cross_vec;
      for (int i = 1; i < EDGE_STEPS; i++) cross_d[i] <= cross_d[i-1];
      cell_d[0] <= coords;
      for (int i = 1; i < CELL_DELAY; i++) cell_d[i] <= cell_d[i-1];
    end
  end

  // partial sums over groups of four cube edges
  logic [GSUM_BITS-1:0] gsum_c [NUM_GROUPS][NUM_AXES];
  logic [GCNT_BITS-1:0] gcnt_c [NUM_GROUPS];
  logic [GSUM_BITS-1:0] gsum_r [NUM_GROUPS][NUM_AXES];
  logic [GCNT_BITS-1:0] gcnt_r [NUM_GROUPS];

  always_comb begin
    logic [2:0] ea;
    logic [2:0] eb;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gcnt_c[g] = '0;
      for (int k = 0; k < NUM_AXES; k++) gsum_c[g][k] = '0;
      for (int j = 0; j < GROUP_EDGES; j++) begin
        ea = edge_a(g * GROUP_EDGES + j);
        eb = edge_b(g * GROUP_EDGES + j);
        if (cross_d[EDGE_STEPS-1][g * GROUP_EDGES + j]) begin
          gcnt_c[g] = gcnt_c[g] + GCNT_BITS'(1);
          for (int k = 0; k < NUM_AXES; k++) begin
            if (ea[k]) gsum_c[g][k] = gsum_c[g][k] + ONE_T;
            if (ea[k] != eb[k])
              gsum_c[g][k] = gsum_c[g][k] + GSUM_BITS'(t_q[g * GROUP_EDGES + j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gsum_r <= gsum_c;
      gcnt_r <= gcnt_c;
    end
  end

  // totals, rounding offset and divisor for the average
  logic [CNT_BITS-1:0]     cnt_c;
  logic [AVG_NUM_BITS-1:0] sum_c    [NUM_AXES];
  logic [AVG_NUM_BITS-1:0] avg_num  [NUM_AXES];
  logic [AVG_DEN_BITS-1:0] avg_den;
  logic                    avg_has;

  always_comb begin
    cnt_c = CNT_BITS'(gcnt_r[0]) + CNT_BITS'(gcnt_r[1]) + CNT_BITS'(gcnt_r[2]);
    for (int k = 0; k < NUM_AXES; k++) begin
      sum_c[k] = AVG_NUM_BITS'(gsum_r[0][k]) + AVG_NUM_BITS'(gsum_r[1][k])
               + AVG_NUM_BITS'(gsum_r[2][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++)
        avg_num[k] <= sum_c[k] + AVG_NUM_BITS'({cnt_c, {(GUARD-1){1'b0}}});
      avg_den <= {cnt_c, {GUARD{1'b0}}};
      avg_has <= cnt_c != '0;
    end
  end

  // averaging divider, three lanes share the divisor
  logic [AVG_NUM_BITS-1:0] arem_q [AVG_STEPS][NUM_AXES];
  logic [AVG_STEPS-1:0]    aquo_q [AVG_STEPS][NUM_AXES];
  logic [AVG_DEN_BITS-1:0] aden_q [AVG_STEPS];
  logic                    ahas_q [AVG_STEPS];

  for (genvar i = 0; i < AVG_STEPS; i++) begin : g_avg
    logic [AVG_DEN_BITS-1:0] den_in;
    logic                    has_in;
    logic [AVG_NUM_BITS:0]   trial;

    if (i == 0) begin : g_first
      assign den_in = avg_den;
      assign has_in = avg_has;
    end else begin : g_next
      assign den_in = aden_q[i-1];
      assign has_in = ahas_q[i-1];
    end

    assign trial = {{(AVG_NUM_BITS + 1 - AVG_DEN_BITS){1'b0}}, den_in} << (AVG_STEPS - 1 - i);

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      logic [AVG_NUM_BITS-1:0] rem_in;
      logic [AVG_STEPS-1:0]    quo_in;
      logic                    ge;

      if (i == 0) begin : g_first
        assign rem_in = avg_num[k];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = arem_q[i-1][k];
        assign quo_in = aquo_q[i-1][k];
      end

      assign ge = {1'b0, rem_in} >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          arem_q[i][k] <= ge ? (rem_in - trial[AVG_NUM_BITS-1:0]) : rem_in;
          aquo_q[i][k] <= {quo_in[AVG_STEPS-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        aden_q[i] <= den_in;
        ahas_q[i] <= has_in;
      end
    end
  end

  // add the cell coordinate, zero when nothing crosses
  function automatic center_t place(input coord_t c, input logic [AVG_STEPS-1:0] f,
                                    input logic h);
    center_t v;
    v = {1'b0, c, {FRAC_BITS{1'b0}}} + CENTER_BITS'(f);
    return h ? v : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      res.has <= ahas_q[AVG_STEPS-1];
      res.x   <= place(cell_d[CELL_DELAY-1][0], aquo_q[AVG_STEPS-1][0], ahas_q[AVG_STEPS-1]);
      res.y   <= place(cell_d[CELL_DELAY-1][1], aquo_q[AVG_STEPS-1][1], ahas_q[AVG_STEPS-1]);
      res.z   <= place(cell_d[CELL_DELAY-1][2], aquo_q[AVG_STEPS-1][2], ahas_q[AVG_STEPS-1]);
    end
  end

endmodule

// ===== hdl/scnv_normal.sv =====
// normal path: gradient, squared length, normalizing divider, pipelined square root
// depends on scnv_pkg
module scnv_normal import scnv_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  sample_t [NUM_CORNERS-1:0] corners,
  output normal_res_t               res
);

  // gradient along each axis
  logic signed [GRAD_BITS-1:0] grad_c [NUM_AXES];
  logic signed [GRAD_BITS-1:0] grad_r [NUM_AXES];

  always_comb begin
    logic signed [GRAD_BITS-1:0] ext;
    for (int k = 0; k < NUM_AXES; k++) grad_c[k] = '0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      ext = GRAD_BITS'(corners[i]);
      for (int k = 0; k < NUM_AXES; k++) begin
        if (((i >> k) & 1) != 0) grad_c[k] = grad_c[k] + ext;
        else                     grad_c[k] = grad_c[k] - ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) grad_r <= grad_c;
  end

  // squares of the components
  logic [SQ_BITS-1:0] sq_r   [NUM_AXES];
  logic [NUM_AXES-1:0] sign_r;

  always_ff @(posedge clk) begin
    logic [GRAD_BITS-1:0] abs_v;
    logic [AG_BITS-1:0]   ag;
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        abs_v = grad_r[k][GRAD_BITS-1] ? (~grad_r[k] + GRAD_BITS'(1)) : grad_r[k];
        ag = abs_v[AG_BITS-1:0];
        sq_r[k]   <= ag * ag;
        sign_r[k] <= grad_r[k][GRAD_BITS-1];
      end
    end
  end

  // squared length
  logic [LEN_BITS-1:0]   len_r;
  logic [SQ_BITS-1:0]    sq2_r [NUM_AXES];
  logic [NUM_AXES:0]     flag_r;
  logic [LEN_BITS-1:0]   len_c;

  assign len_c = LEN_BITS'(sq_r[0]) + LEN_BITS'(sq_r[1]) + LEN_BITS'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      len_r  <= len_c;
      sq2_r  <= sq_r;
      flag_r <= {sign_r, len_c == '0};
    end
  end

  // divider: square of the component over the squared length, one bit per stage
  logic [LEN_BITS-1:0] drem_q [QDIV_STEPS][NUM_AXES];
  logic [Q_BITS-1:0]   dquo_q [QDIV_STEPS][NUM_AXES];
  logic [LEN_BITS-1:0] dlen_q [QDIV_STEPS];

  for (genvar i = 0; i < QDIV_STEPS; i++) begin : g_div
    logic [LEN_BITS-1:0] len_in;

    if (i == 0) begin : g_first
      assign len_in = len_r;
    end else begin : g_next
      assign len_in = dlen_q[i-1];
    end

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      logic [LEN_BITS-1:0] rem_in;
      logic [Q_BITS-1:0]   quo_in;
      logic [LEN_BITS:0]   trial;
      logic                ge;

      if (i == 0) begin : g_first
        assign rem_in = LEN_BITS'(sq2_r[k]);
        assign quo_in = '0;
        assign trial  = {1'b0, rem_in};
      end else begin : g_next
        assign rem_in = drem_q[i-1][k];
        assign quo_in = dquo_q[i-1][k];
        assign trial  = {rem_in, 1'b0};
      end

      assign ge = trial >= {1'b0, len_in};

      always_ff @(posedge clk) begin
        if (en) begin
          drem_q[i][k] <= ge ? LEN_BITS'(trial - {1'b0, len_in}) : trial[LEN_BITS-1:0];
          dquo_q[i][k] <= {quo_in[Q_BITS-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) dlen_q[i] <= len_in;
    end
  end

  // square root, one result bit per stage
  logic [ROOT_BITS-1:0] rv_q [ROOT_STEPS][NUM_AXES];
  logic [ROOT_BITS-1:0] rr_q [ROOT_STEPS][NUM_AXES];

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    localparam logic [ROOT_BITS-1:0] BIT = ROOT_BITS'(1) << (2 * (ROOT_STEPS - 1 - i));

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      logic [ROOT_BITS-1:0] v_in;
      logic [ROOT_BITS-1:0] r_in;
      logic [ROOT_BITS:0]   try_v;
      logic                 ge;

      if (i == 0) begin : g_first
        assign v_in = ROOT_BITS'(dquo_q[QDIV_STEPS-1][k]);
        assign r_in = '0;
      end else begin : g_next
        assign v_in = rv_q[i-1][k];
        assign r_in = rr_q[i-1][k];
      end

      assign try_v = {1'b0, r_in} + {1'b0, BIT};
      assign ge    = {1'b0, v_in} >= try_v;

      always_ff @(posedge clk) begin
        if (en) begin
          rv_q[i][k] <= ge ? ROOT_BITS'({1'b0, v_in} - try_v) : v_in;
          rr_q[i][k] <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
        end
      end
    end
  end

  // signs and zero length follow the divider and root stages
  logic [NUM_AXES:0] flag_d [FLAG_DELAY];

  always_ff @(posedge clk) begin
    if (en) begin
      flag_d[0] <= flag_r;
      for (int i = 1; i < FLAG_DELAY; i++) flag_d[i] <= flag_d[i-1];
    end
  end

  // round, apply sign, force zero on a zero-length gradient
  function automatic normal_t finish(input logic [ROOT_BITS-1:0] r, input logic neg,
                                     input logic zero);
    logic [NORMAL_BITS:0] rnd;
    normal_t              mag;
    rnd = NORMAL_BITS'(r) + (NORMAL_BITS + 1)'(1);
    mag = rnd[NORMAL_BITS:1];
    if (zero) return '0;
    return neg ? -mag : mag;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      res.x    <= finish(rr_q[ROOT_STEPS-1][0], flag_d[FLAG_DELAY-1][1],
                         flag_d[FLAG_DELAY-1][0]);
      res.y    <= finish(rr_q[ROOT_STEPS-1][1], flag_d[FLAG_DELAY-1][2],
                         flag_d[FLAG_DELAY-1][0]);
      res.z    <= finish(rr_q[ROOT_STEPS-1][2], flag_d[FLAG_DELAY-1][3],
                         flag_d[FLAG_DELAY-1][0]);
      res.zero <= flag_d[FLAG_DELAY-1][0];
    end
  end

endmodule
